FILE: rtl/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg
// Shared types, codes and helper functions for the alarm clock controller.
// ----------------------------------------------------------------------------
package acc_pkg;

    localparam int unsigned STATE_W  = 4;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned RING_W   = 6;
    localparam int unsigned OFF_W    = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 6;

    localparam logic [STATE_W-1:0] ST_CLOCK      = 4'd0;
    localparam logic [STATE_W-1:0] ST_SET_HOUR   = 4'd1;
    localparam logic [STATE_W-1:0] ST_SET_MINUTE = 4'd2;
    localparam logic [STATE_W-1:0] ST_AL_HOUR    = 4'd3;
    localparam logic [STATE_W-1:0] ST_AL_MINUTE  = 4'd4;
    localparam logic [STATE_W-1:0] ST_RINGING    = 4'd5;
    localparam logic [STATE_W-1:0] ST_MENU_SET   = 4'd6;
    localparam logic [STATE_W-1:0] ST_MENU_AL    = 4'd7;
    localparam logic [STATE_W-1:0] ST_OFF_NOTICE = 4'd8;
    localparam logic [STATE_W-1:0] ST_LAST       = 4'd8;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_PRESS = 1'b1;

    localparam logic [1:0] BTN_MENU  = 2'd0;
    localparam logic [1:0] BTN_OK    = 2'd1;
    localparam logic [1:0] BTN_PLUS  = 2'd2;
    localparam logic [1:0] BTN_MINUS = 2'd3;

    localparam logic [1:0] TXT_DIGITS = 2'd0;
    localparam logic [1:0] TXT_SET    = 2'd1;
    localparam logic [1:0] TXT_AL     = 2'd2;
    localparam logic [1:0] TXT_OFF    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS    = 2'd2;

    localparam logic [HOUR_W-1:0]   HOUR_MAX       = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX     = 6'd59;
    localparam logic [RING_W-1:0]   RING_TICKS_RST = 6'd60;
    localparam logic [OFF_W-1:0]    OFF_TICKS_RST  = 3'd6;

    typedef struct packed {
        logic [1:0]         text_mode;
        logic [1:0]         hour_tens;
        logic [3:0]         hour_units;
        logic [2:0]         minute_tens;
        logic [3:0]         minute_units;
        logic               hour_visible;
        logic               minute_visible;
        logic               colon_on;
        logic               buzzer_pulse;
        logic [STATE_W-1:0] menu_state;
    } result_t;

    function automatic logic [HOUR_W-1:0] hour_adjust(logic [HOUR_W-1:0] h, logic up);
        if (up) begin
            return (h >= HOUR_MAX) ? '0 : h + 5'd1;
        end
        return (h == '0 || h > HOUR_MAX) ? HOUR_MAX : h - 5'd1;
    endfunction

    function automatic logic [MINUTE_W-1:0] minute_adjust(logic [MINUTE_W-1:0] m, logic up);
        if (up) begin
            return (m >= MINUTE_MAX) ? '0 : m + 6'd1;
        end
        return (m == '0 || m > MINUTE_MAX) ? MINUTE_MAX : m - 6'd1;
    endfunction

    function automatic logic [2:0] bcd_tens(logic [MINUTE_W-1:0] v);
        if (v >= 6'd50) return 3'd5;
        if (v >= 6'd40) return 3'd4;
        if (v >= 6'd30) return 3'd3;
        if (v >= 6'd20) return 3'd2;
        if (v >= 6'd10) return 3'd1;
        return 3'd0;
    endfunction

    function automatic logic [3:0] bcd_units(logic [MINUTE_W-1:0] v);
        logic [MINUTE_W-1:0] tens;
        logic [MINUTE_W-1:0] rem;
        tens = {3'b000, bcd_tens(v)};
        rem  = v - tens * 6'd10;
        return rem[3:0];
    endfunction

endpackage

FILE: rtl/alarm_clock_controller.sv
// ----------------------------------------------------------------------------
// alarm_clock_controller
// 24-hour alarm clock with a four-button menu and one alarm.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per half-second tick (s_action 0) or button press
//   (s_action 1, s_button selects menu, ok, plus or minus).
//   m_ channel: one display item for every tick; presses give none.
//   cfg_ port: write alarm_enable, ring_ticks and off_notice_ticks while idle.
// Timing:
//   An accepted item is registered in the input register; when it steps, it is
//   applied to the clock state, and a tick's display item is loaded into the
//   result register, which drives m_valid.
//   One item per cycle is taken while the result register has room.
// Reset:
//   Clock and alarm time at 00:00:00, clock view, colon phase low, timers
//   cleared; registers take 0, 60 and 6.
// Stall:
//   A held result stays on m_ until taken; a tick then waits in the input
//   register and s_ready drops; button presses flow on only while no tick waits.
// ----------------------------------------------------------------------------
module alarm_clock_controller
    import acc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [1:0]            s_button,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_text_mode,
    output logic [1:0]            m_hour_tens,
    output logic [3:0]            m_hour_units,
    output logic [2:0]            m_minute_tens,
    output logic [3:0]            m_minute_units,
    output logic                  m_hour_visible,
    output logic                  m_minute_visible,
    output logic                  m_colon_on,
    output logic                  m_buzzer_pulse,
    output logic [STATE_W-1:0]    m_menu_state_out
);

    logic       in_valid_reg, in_valid_next;
    logic       in_action_reg;
    logic [1:0] in_button_reg;
    logic       step;
    logic       out_space;
    logic       res_valid;
    result_t    res;
    result_t    res_q;

    assign step    = in_valid_reg && (in_action_reg == ACT_PRESS || out_space);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_button_reg <= s_button;
        end
    end

    acc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .action    (in_action_reg),
        .button    (in_button_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    acc_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (res_valid),
        .res_in  (res),
        .space   (out_space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res_out (res_q)
    );

    assign m_text_mode      = res_q.text_mode;
    assign m_hour_tens      = res_q.hour_tens;
    assign m_hour_units     = res_q.hour_units;
    assign m_minute_tens    = res_q.minute_tens;
    assign m_minute_units   = res_q.minute_units;
    assign m_hour_visible   = res_q.hour_visible;
    assign m_minute_visible = res_q.minute_visible;
    assign m_colon_on       = res_q.colon_on;
    assign m_buzzer_pulse   = res_q.buzzer_pulse;
    assign m_menu_state_out = res_q.menu_state;

endmodule

FILE: rtl/acc_core.sv
// ----------------------------------------------------------------------------
// acc_core
// Clock, alarm and menu state, updated for one item at each step.
// ----------------------------------------------------------------------------
module acc_core
    import acc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  step,
    input  logic                  action,
    input  logic [1:0]            button,
    output logic                  res_valid,
    output result_t               res
);

    logic               alarm_en_reg;
    logic [RING_W-1:0]  ring_ticks_reg;
    logic [OFF_W-1:0]   off_ticks_reg;

    logic [STATE_W-1:0]  state_reg,   state_next;
    logic [HOUR_W-1:0]   hours_reg,   hours_next;
    logic [MINUTE_W-1:0] minutes_reg, minutes_next;
    logic [MINUTE_W-1:0] seconds_reg, seconds_next;
    logic [HOUR_W-1:0]   al_hours_reg,   al_hours_next;
    logic [MINUTE_W-1:0] al_minutes_reg, al_minutes_next;
    logic                phase_reg,   phase_next;
    logic [RING_W-1:0]   ring_reg,    ring_next;
    logic [OFF_W-1:0]    off_reg,     off_next;

    // tick path intermediates
    logic                phase_t;
    logic [HOUR_W-1:0]   hours_t;
    logic [MINUTE_W-1:0] minutes_t;
    logic [MINUTE_W-1:0] seconds_t;
    logic                alarm_hit;
    logic [STATE_W-1:0]  state_t;
    logic [RING_W-1:0]   ring_t;
    logic [RING_W-1:0]   ring_dec;
    logic [OFF_W-1:0]    off_dec;
    logic [HOUR_W-1:0]   shown_h;
    logic [MINUTE_W-1:0] shown_m;
    logic [2:0]          hour_tens_full;
    logic                digits;

    always_comb begin
        phase_t   = ~phase_reg;
        hours_t   = hours_reg;
        minutes_t = minutes_reg;
        seconds_t = seconds_reg;
        if (phase_t) begin
            if (seconds_reg < MINUTE_MAX) begin
                seconds_t = seconds_reg + 6'd1;
            end else begin
                seconds_t = '0;
                if (minutes_reg < MINUTE_MAX) begin
                    minutes_t = minutes_reg + 6'd1;
                end else begin
                    minutes_t = '0;
                    hours_t   = (hours_reg < HOUR_MAX) ? hours_reg + 5'd1 : '0;
                end
            end
        end
        alarm_hit = phase_t && alarm_en_reg
                    && (state_reg == ST_CLOCK || state_reg > ST_LAST)
                    && hours_t == al_hours_reg && minutes_t == al_minutes_reg
                    && seconds_t == '0;
        state_t  = alarm_hit ? ST_RINGING : state_reg;
        ring_t   = alarm_hit ? ring_ticks_reg : ring_reg;
        ring_dec = ring_t - 6'd1;
        off_dec  = off_reg - 3'd1;
    end

    always_comb begin
        state_next      = state_reg;
        hours_next      = hours_reg;
        minutes_next    = minutes_reg;
        seconds_next    = seconds_reg;
        al_hours_next   = al_hours_reg;
        al_minutes_next = al_minutes_reg;
        phase_next      = phase_reg;
        ring_next       = ring_reg;
        off_next        = off_reg;
        res             = '0;
        res_valid       = 1'b0;
        shown_h         = hours_t;
        shown_m         = minutes_t;
        hour_tens_full  = '0;
        digits          = 1'b1;

        if (step && action == ACT_PRESS) begin
            case (state_reg)
                ST_SET_HOUR, ST_SET_MINUTE: begin
                    if (button == BTN_OK) begin
                        state_next = (state_reg == ST_SET_HOUR) ? ST_SET_MINUTE : ST_CLOCK;
                    end else if (button == BTN_PLUS || button == BTN_MINUS) begin
                        if (state_reg == ST_SET_HOUR) begin
                            hours_next = hour_adjust(hours_reg, button == BTN_PLUS);
                        end else begin
                            minutes_next = minute_adjust(minutes_reg, button == BTN_PLUS);
                        end
                        seconds_next = '0;
                    end
                end
                ST_AL_HOUR, ST_AL_MINUTE: begin
                    if (button == BTN_OK) begin
                        state_next = (state_reg == ST_AL_HOUR) ? ST_AL_MINUTE : ST_CLOCK;
                    end else if (button == BTN_PLUS || button == BTN_MINUS) begin
                        if (state_reg == ST_AL_HOUR) begin
                            al_hours_next = hour_adjust(al_hours_reg, button == BTN_PLUS);
                        end else begin
                            al_minutes_next = minute_adjust(al_minutes_reg,
                                                            button == BTN_PLUS);
                        end
                    end
                end
                ST_RINGING: begin
                    if (button == BTN_OK) begin
                        state_next = ST_CLOCK;
                        ring_next  = '0;
                    end
                end
                ST_MENU_SET: begin
                    if (button == BTN_MENU) begin
                        state_next = ST_MENU_AL;
                    end else if (button == BTN_OK) begin
                        state_next = ST_SET_HOUR;
                    end
                end
                ST_MENU_AL: begin
                    if (button == BTN_MENU) begin
                        state_next = ST_CLOCK;
                    end else if (button == BTN_OK) begin
                        if (alarm_en_reg) begin
                            state_next = ST_AL_HOUR;
                        end else begin
                            state_next = ST_OFF_NOTICE;
                            off_next   = off_ticks_reg;
                        end
                    end
                end
                ST_OFF_NOTICE: begin
                end
                default: begin
                    if (button == BTN_MENU) begin
                        state_next = ST_MENU_SET;
                    end
                end
            endcase
        end else if (step) begin
            res_valid    = 1'b1;
            phase_next   = phase_t;
            hours_next   = hours_t;
            minutes_next = minutes_t;
            seconds_next = seconds_t;
            state_next   = state_t;
            ring_next    = ring_t;
            case (state_t)
                ST_SET_HOUR: begin
                    res.colon_on = 1'b1; res.hour_visible = phase_t; res.minute_visible = 1'b1;
                end
                ST_SET_MINUTE: begin
                    res.colon_on = 1'b1; res.hour_visible = 1'b1; res.minute_visible = phase_t;
                end
                ST_AL_HOUR: begin
                    shown_h = al_hours_reg; shown_m = al_minutes_reg;
                    res.colon_on = 1'b1; res.hour_visible = phase_t; res.minute_visible = 1'b1;
                end
                ST_AL_MINUTE: begin
                    shown_h = al_hours_reg; shown_m = al_minutes_reg;
                    res.colon_on = 1'b1; res.hour_visible = 1'b1; res.minute_visible = phase_t;
                end
                ST_RINGING: begin
                    res.colon_on       = 1'b1;
                    res.hour_visible   = phase_t;
                    res.minute_visible = phase_t;
                    res.buzzer_pulse   = 1'b1;
                    ring_next          = ring_dec;
                    if (ring_dec == '0) begin
                        state_next = ST_CLOCK;
                    end
                end
                ST_MENU_SET: begin
                    digits = 1'b0; res.text_mode = TXT_SET;
                end
                ST_MENU_AL: begin
                    digits = 1'b0; res.text_mode = TXT_AL;
                end
                ST_OFF_NOTICE: begin
                    digits        = 1'b0;
                    res.text_mode = TXT_OFF;
                    off_next      = off_dec;
                    if (off_dec == '0) begin
                        state_next = ST_CLOCK;
                    end
                end
                default: begin
                    res.colon_on = phase_t; res.hour_visible = 1'b1; res.minute_visible = 1'b1;
                end
            endcase
            if (digits) begin
                hour_tens_full   = bcd_tens({1'b0, shown_h});
                res.hour_tens    = hour_tens_full[1:0];
                res.hour_units   = bcd_units({1'b0, shown_h});
                res.minute_tens  = bcd_tens(shown_m);
                res.minute_units = bcd_units(shown_m);
            end
            res.menu_state = state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_en_reg   <= 1'b0;
            ring_ticks_reg <= RING_TICKS_RST;
            off_ticks_reg  <= OFF_TICKS_RST;
            state_reg      <= ST_CLOCK;
            hours_reg      <= '0;
            minutes_reg    <= '0;
            seconds_reg    <= '0;
            al_hours_reg   <= '0;
            al_minutes_reg <= '0;
            phase_reg      <= 1'b0;
            ring_reg       <= '0;
            off_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_ALARM_ENABLE: alarm_en_reg   <= cfg_wdata[0];
                    CFG_RING_TICKS:   ring_ticks_reg <= cfg_wdata[RING_W-1:0];
                    CFG_OFF_TICKS:    off_ticks_reg  <= cfg_wdata[OFF_W-1:0];
                    default: ;
                endcase
            end
            state_reg      <= state_next;
            hours_reg      <= hours_next;
            minutes_reg    <= minutes_next;
            seconds_reg    <= seconds_next;
            al_hours_reg   <= al_hours_next;
            al_minutes_reg <= al_minutes_next;
            phase_reg      <= phase_next;
            ring_reg       <= ring_next;
            off_reg        <= off_next;
        end
    end

endmodule

FILE: rtl/acc_out.sv
// ----------------------------------------------------------------------------
// acc_out
// Result register with valid/ready hand-off to the display side.
// ----------------------------------------------------------------------------
module acc_out
    import acc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    output logic    space,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t res_out
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign res_out = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the alarm clock controller.
// Ticks and button presses go in on the s_ channel. A model of the clock and
// its menu, kept in step with every accepted item, predicts each display item.
// The bench compares every m_ item with the oldest prediction. The run covers
// menu walks, time and alarm edits with wrap, midnight rollover, the OFF
// notice, and alarms that are stopped early, that run out, or whose timer
// wraps. Back-pressure and idle gaps vary on both sides, with one long output
// stall.
// ----------------------------------------------------------------------------
module testbench;
    import acc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic       action;
        logic [1:0] button;
    } clock_event_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_action  = ACT_TICK;
    logic [1:0]            s_button  = BTN_MENU;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [1:0]            m_text_mode;
    logic [1:0]            m_hour_tens;
    logic [3:0]            m_hour_units;
    logic [2:0]            m_minute_tens;
    logic [3:0]            m_minute_units;
    logic                  m_hour_visible;
    logic                  m_minute_visible;
    logic                  m_colon_on;
    logic                  m_buzzer_pulse;
    logic [STATE_W-1:0]    m_menu_state_out;

    // clock and menu state as the block should hold it
    logic [STATE_W-1:0]  menu_now    = ST_CLOCK;
    logic [HOUR_W-1:0]   clk_hours   = '0;
    logic [MINUTE_W-1:0] clk_minutes = '0;
    logic [MINUTE_W-1:0] clk_seconds = '0;
    logic [HOUR_W-1:0]   al_hours    = '0;
    logic [MINUTE_W-1:0] al_minutes  = '0;
    logic                colon_phase = 1'b0;
    logic [RING_W-1:0]   ring_left   = '0;
    logic [OFF_W-1:0]    off_left    = '0;
    logic                alarm_armed = 1'b0;
    logic [RING_W-1:0]   ring_len    = RING_TICKS_RST;
    logic [OFF_W-1:0]    off_len     = OFF_TICKS_RST;

    clock_event_t pending_events[$];
    result_t      display_expected[$];
    clock_event_t next_event;
    result_t      shown;
    result_t      wanted;

    int src_gap_pct      = 0;
    int sink_gap_pct     = 0;
    int hold_req_seq     = 0;
    int hold_req_len     = 0;
    int hold_ack_seq     = 0;
    int hold_left        = 0;
    int events_accepted  = 0;
    int displays_checked = 0;
    int buzzer_displays  = 0;
    int mismatch_count   = 0;
    int idle_cycles      = 0;

    alarm_clock_controller u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_button         (s_button),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_text_mode      (m_text_mode),
        .m_hour_tens      (m_hour_tens),
        .m_hour_units     (m_hour_units),
        .m_minute_tens    (m_minute_tens),
        .m_minute_units   (m_minute_units),
        .m_hour_visible   (m_hour_visible),
        .m_minute_visible (m_minute_visible),
        .m_colon_on       (m_colon_on),
        .m_buzzer_pulse   (m_buzzer_pulse),
        .m_menu_state_out (m_menu_state_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int wrap_step(int v, int modulus, logic up);
        return up ? (v + 1) % modulus : (v + modulus - 1) % modulus;
    endfunction

    function automatic string describe_display(result_t r);
        return $sformatf("mode %0d %0d%0d:%0d%0d vis %b%b colon %b buzz %b state %0d",
                         r.text_mode, r.hour_tens, r.hour_units, r.minute_tens,
                         r.minute_units, r.hour_visible, r.minute_visible,
                         r.colon_on, r.buzzer_pulse, r.menu_state);
    endfunction

    task automatic apply_press(input logic [1:0] button);
        logic up;
        up = (button == BTN_PLUS);
        case (menu_now)
            ST_SET_HOUR, ST_SET_MINUTE: begin
                if (button == BTN_OK) begin
                    menu_now = (menu_now == ST_SET_HOUR) ? ST_SET_MINUTE : ST_CLOCK;
                end else if (button == BTN_PLUS || button == BTN_MINUS) begin
                    if (menu_now == ST_SET_HOUR) begin
                        clk_hours = HOUR_W'(wrap_step(clk_hours, 24, up));
                    end else begin
                        clk_minutes = MINUTE_W'(wrap_step(clk_minutes, 60, up));
                    end
                    clk_seconds = '0;
                end
            end
            ST_AL_HOUR, ST_AL_MINUTE: begin
                if (button == BTN_OK) begin
                    menu_now = (menu_now == ST_AL_HOUR) ? ST_AL_MINUTE : ST_CLOCK;
                end else if (button == BTN_PLUS || button == BTN_MINUS) begin
                    if (menu_now == ST_AL_HOUR) begin
                        al_hours = HOUR_W'(wrap_step(al_hours, 24, up));
                    end else begin
                        al_minutes = MINUTE_W'(wrap_step(al_minutes, 60, up));
                    end
                end
            end
            ST_RINGING: begin
                if (button == BTN_OK) begin
                    menu_now  = ST_CLOCK;
                    ring_left = '0;
                end
            end
            ST_MENU_SET: begin
                if (button == BTN_MENU) begin
                    menu_now = ST_MENU_AL;
                end else if (button == BTN_OK) begin
                    menu_now = ST_SET_HOUR;
                end
            end
            ST_MENU_AL: begin
                if (button == BTN_MENU) begin
                    menu_now = ST_CLOCK;
                end else if (button == BTN_OK) begin
                    if (alarm_armed) begin
                        menu_now = ST_AL_HOUR;
                    end else begin
                        menu_now = ST_OFF_NOTICE;
                        off_left = off_len;
                    end
                end
            end
            ST_OFF_NOTICE: ;
            default: begin
                if (button == BTN_MENU) begin
                    menu_now = ST_MENU_SET;
                end
            end
        endcase
    endtask

    task automatic apply_tick();
        result_t             r;
        logic [HOUR_W-1:0]   hh;
        logic [MINUTE_W-1:0] mm;
        colon_phase = ~colon_phase;
        if (colon_phase) begin
            if (clk_seconds < MINUTE_MAX) begin
                clk_seconds++;
            end else begin
                clk_seconds = '0;
                if (clk_minutes < MINUTE_MAX) begin
                    clk_minutes++;
                end else begin
                    clk_minutes = '0;
                    clk_hours   = (clk_hours < HOUR_MAX) ? clk_hours + 1'b1 : '0;
                end
            end
            if (menu_now == ST_CLOCK && alarm_armed && clk_hours == al_hours &&
                clk_minutes == al_minutes && clk_seconds == '0) begin
                menu_now  = ST_RINGING;
                ring_left = ring_len;
            end
        end
        r  = '0;
        hh = clk_hours;
        mm = clk_minutes;
        case (menu_now)
            ST_SET_HOUR: begin
                r.colon_on       = 1'b1;
                r.hour_visible   = colon_phase;
                r.minute_visible = 1'b1;
            end
            ST_SET_MINUTE: begin
                r.colon_on       = 1'b1;
                r.hour_visible   = 1'b1;
                r.minute_visible = colon_phase;
            end
            ST_AL_HOUR: begin
                hh               = al_hours;
                mm               = al_minutes;
                r.colon_on       = 1'b1;
                r.hour_visible   = colon_phase;
                r.minute_visible = 1'b1;
            end
            ST_AL_MINUTE: begin
                hh               = al_hours;
                mm               = al_minutes;
                r.colon_on       = 1'b1;
                r.hour_visible   = 1'b1;
                r.minute_visible = colon_phase;
            end
            ST_RINGING: begin
                r.colon_on       = 1'b1;
                r.hour_visible   = colon_phase;
                r.minute_visible = colon_phase;
                r.buzzer_pulse   = 1'b1;
                ring_left        = ring_left - 1'b1;
                if (ring_left == '0) begin
                    menu_now = ST_CLOCK;
                end
            end
            ST_MENU_SET: r.text_mode = TXT_SET;
            ST_MENU_AL:  r.text_mode = TXT_AL;
            ST_OFF_NOTICE: begin
                r.text_mode = TXT_OFF;
                off_left    = off_left - 1'b1;
                if (off_left == '0) begin
                    menu_now = ST_CLOCK;
                end
            end
            default: begin
                r.colon_on       = colon_phase;
                r.hour_visible   = 1'b1;
                r.minute_visible = 1'b1;
            end
        endcase
        if (r.text_mode == TXT_DIGITS) begin
            r.hour_tens    = 2'(hh / 10);
            r.hour_units   = 4'(hh % 10);
            r.minute_tens  = 3'(mm / 10);
            r.minute_units = 4'(mm % 10);
        end
        r.menu_state = menu_now;
        display_expected.push_back(r);
    endtask

    task automatic report_display(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t %s: expected %s, got %s", $time, what,
                     describe_display(want), describe_display(got));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_action == ACT_PRESS) begin
                    apply_press(s_button);
                end else begin
                    apply_tick();
                end
                events_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    next_event = pending_events.pop_front();
                    s_valid   <= 1'b1;
                    s_action  <= next_event.action;
                    s_button  <= next_event.button;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                shown.text_mode      = m_text_mode;
                shown.hour_tens      = m_hour_tens;
                shown.hour_units     = m_hour_units;
                shown.minute_tens    = m_minute_tens;
                shown.minute_units   = m_minute_units;
                shown.hour_visible   = m_hour_visible;
                shown.minute_visible = m_minute_visible;
                shown.colon_on       = m_colon_on;
                shown.buzzer_pulse   = m_buzzer_pulse;
                shown.menu_state     = m_menu_state_out;
                if (display_expected.size() == 0) begin
                    report_display("display item with nothing pending", '0, shown);
                end else begin
                    wanted = display_expected.pop_front();
                    if (shown !== wanted) begin
                        report_display("display mismatch", wanted, shown);
                    end
                end
                displays_checked++;
                if (shown.buzzer_pulse) begin
                    buzzer_displays++;
                end
            end
            if (hold_ack_seq != hold_req_seq) begin
                hold_ack_seq = hold_req_seq;
                hold_left    = hold_req_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_gap_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_event(input logic action, input logic [1:0] button);
        clock_event_t ev;
        ev.action = action;
        ev.button = button;
        pending_events.push_back(ev);
    endtask

    task automatic queue_press(input logic [1:0] button);
        queue_event(ACT_PRESS, button);
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) begin
            queue_event(ACT_TICK, 2'($urandom_range(3)));
        end
    endtask

    task automatic queue_noise(input int n);
        repeat (n) begin
            if ($urandom_range(99) < 55) begin
                queue_ticks(1);
            end else begin
                queue_press(2'($urandom_range(3)));
            end
        end
    endtask

    task automatic settle();
        do begin
            @(negedge aclk);
        end while (pending_events.size() != 0 || s_valid || display_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ALARM_ENABLE: alarm_armed = (val != 0);
            CFG_RING_TICKS:   ring_len    = RING_W'(val);
            CFG_OFF_TICKS:    off_len     = OFF_W'(val);
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic queue_steps(input int from, input int to, input int modulus);
        int d;
        d = (to - from + modulus) % modulus;
        if (d <= modulus / 2) begin
            repeat (d) queue_press(BTN_PLUS);
        end else begin
            repeat (modulus - d) queue_press(BTN_MINUS);
        end
    endtask

    task automatic queue_set_time(input int h, input int m);
        queue_press(BTN_MENU);
        queue_press(BTN_OK);
        queue_steps(clk_hours, h, 24);
        queue_press(BTN_OK);
        queue_steps(clk_minutes, m, 60);
        // zero the seconds even when the minutes are already right
        queue_press(BTN_PLUS);
        queue_press(BTN_MINUS);
        queue_press(BTN_OK);
    endtask

    task automatic queue_set_alarm(input int h, input int m);
        queue_press(BTN_MENU);
        queue_press(BTN_MENU);
        queue_press(BTN_OK);
        queue_steps(al_hours, h, 24);
        queue_press(BTN_OK);
        queue_steps(al_minutes, m, 60);
        queue_press(BTN_OK);
    endtask

    task automatic return_to_clock_view();
        settle();
        while (menu_now != ST_CLOCK) begin
            case (menu_now)
                ST_OFF_NOTICE:          queue_ticks(1);
                ST_MENU_SET, ST_MENU_AL: queue_press(BTN_MENU);
                default:                queue_press(BTN_OK);
            endcase
            settle();
        end
    endtask

    task automatic queue_alarm_run(input int h, input int m, input bit stop_early);
        return_to_clock_view();
        queue_set_alarm(h, m);
        queue_set_time((m == 0) ? (h + 23) % 24 : h, (m + 59) % 60);
        queue_ticks(121);
        settle();
        if (stop_early) begin
            queue_ticks($urandom_range(6, 2));
            queue_press(BTN_PLUS);
            queue_press(BTN_MENU);
            queue_press(BTN_MINUS);
            queue_press(BTN_OK);
            queue_ticks(2);
        end else begin
            queue_ticks((ring_len == '0) ? 66 : int'(ring_len) + 2);
        end
    endtask

    task automatic hold_display(input int cycles);
        hold_req_len = cycles;
        hold_req_seq++;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_gap_pct  = 17;
        sink_gap_pct = 71;
        write_reg(CFG_OFF_TICKS, 1);
        queue_ticks(2);
        queue_press(BTN_MINUS);
        queue_press(BTN_OK);
        queue_press(BTN_MENU);
        queue_ticks(1);
        queue_press(BTN_PLUS);
        queue_press(BTN_MENU);
        queue_ticks(1);
        // alarm disarmed: OK shows the OFF notice
        queue_press(BTN_OK);
        queue_press(BTN_MENU);
        queue_ticks(1);
        queue_press(BTN_MENU);
        queue_press(BTN_OK);
        queue_press(BTN_MINUS);
        queue_ticks(1);
        queue_press(BTN_PLUS);
        queue_press(BTN_MINUS);
        queue_press(BTN_MENU);
        queue_press(BTN_OK);
        queue_press(BTN_MINUS);
        queue_ticks(1);
        queue_press(BTN_PLUS);
        queue_press(BTN_MINUS);
        queue_press(BTN_OK);
        queue_ticks(2);
        settle();

        write_reg(CFG_ALARM_ENABLE, 1);
        write_reg(CFG_RING_TICKS, 63);
        write_reg(CFG_OFF_TICKS, 7);
        queue_alarm_run($urandom_range(23), $urandom_range(59), 1'b1);
        queue_noise(15);
        settle();

        src_gap_pct  = 71;
        sink_gap_pct = 17;
        write_reg(CFG_RING_TICKS, 0);
        write_reg(CFG_OFF_TICKS, 0);
        queue_alarm_run($urandom_range(23), $urandom_range(59), 1'b0);
        settle();
        write_reg(CFG_ALARM_ENABLE, 0);
        queue_noise(15);
        settle();

        src_gap_pct  = 0;
        sink_gap_pct = 0;
        write_reg(CFG_ALARM_ENABLE, 1);
        write_reg(CFG_RING_TICKS, 1);
        write_reg(CFG_OFF_TICKS, 3);
        // ring at midnight, crossing 23:59:59
        queue_alarm_run(0, 0, 1'b0);
        queue_noise(10);
        settle();
        hold_display(200);
        queue_ticks(12);
        queue_noise(8);
        settle();
        write_reg(CFG_ALARM_ENABLE, 0);
        queue_noise(10);
        settle();
        repeat (8) @(negedge aclk);

        $display("%0d items taken, %0d display items checked, %0d of them ringing",
                 events_accepted, displays_checked, buzzer_displays);
        $display("menu walk, edits with wrap, OFF notice, three alarms, long output stall");
        if (mismatch_count == 0 && display_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
